// ----- hw/rtl/rdz_pkg.sv -----
// Shared constants, types and tables of the radial deadzone stick conditioner.
package rdz_pkg;

  localparam int AXIS_BITS = 16;
  localparam logic [14:0] FULL_SCALE = 15'((1 << (AXIS_BITS - 1)) - 1);
  localparam logic [14:0] DZ_RESET = 15'd8000;
  localparam logic [23:0] HALF_PI_U20 = 24'd1647099;
  localparam logic [16:0] ANGLE_MAX = 17'd25736;

  // Divider operand widths
  localparam int DIV_W = 40;
  localparam int DSR_W = 24;

  // Configuration register indexes
  localparam logic REG_DZ_LEFT = 1'b0;
  localparam logic REG_DZ_RIGHT = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_LEFT = 2'd0;
  localparam logic [1:0] KIND_RIGHT = 2'd1;
  localparam logic [1:0] KIND_TRIG = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // Axis slots
  localparam logic [2:0] SLOT_LX = 3'd0;
  localparam logic [2:0] SLOT_LY = 3'd1;
  localparam logic [2:0] SLOT_LT = 3'd2;
  localparam logic [2:0] SLOT_RX = 3'd3;
  localparam logic [2:0] SLOT_RY = 3'd4;
  localparam logic [2:0] SLOT_RT = 3'd5;
  localparam logic [2:0] SLOT_DPX = 3'd6;
  localparam logic [2:0] SLOT_DPY = 3'd7;

  // Request to the shared divider
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DSR_W-1:0]   divisor;
  } rdz_div_req_t;

  // CORDIC step angles, units of 2^-20 rad
  function automatic logic [19:0] atan_step(input logic [3:0] i);
    logic [19:0] a;
    case (i)
      4'd0:    a = 20'd823550;
      4'd1:    a = 20'd486170;
      4'd2:    a = 20'd256879;
      4'd3:    a = 20'd130396;
      4'd4:    a = 20'd65451;
      4'd5:    a = 20'd32757;
      4'd6:    a = 20'd16383;
      4'd7:    a = 20'd8192;
      4'd8:    a = 20'd4096;
      4'd9:    a = 20'd2048;
      4'd10:   a = 20'd1024;
      4'd11:   a = 20'd512;
      4'd12:   a = 20'd256;
      4'd13:   a = 20'd128;
      4'd14:   a = 20'd64;
      default: a = 20'd32;
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/radial_deadzone_stick_conditioner_unit.sv -----
// Top level: axis store, sequencer, multiplier, square root and CORDIC.
//
//  channel | handshake               | payload
//  in      | in_valid / in_ready     | axis_code, axis_value
//  out     | out_valid / out_ready   | update_kind, stick_*, left/right_trigger
//  cfg     | cfg_wr_en               | cfg_index, cfg_data
//
// Stick request: load, square x, square y, deadzone compare, 24 square-root steps,
// three divisions in the shared divider, a quarter-turn step, 16 CORDIC steps and
// the result write. A deadzone at full scale skips the magnitude division; inside
// the deadzone the request goes straight to the result write, as do trigger and
// DPad requests. Unmapped codes are accepted and dropped without a result.
// in_ready is high only while the sequencer is idle; a held result in the
// output register does not block the next request until it must be written.
// Synchronous reset clears axes to zero and both deadzones to 8000.
module radial_deadzone_stick_conditioner_unit
  import rdz_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         axis_code,
  input  logic signed [15:0] axis_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         update_kind,
  output logic signed [15:0] stick_x,
  output logic signed [15:0] stick_y,
  output logic [15:0]        stick_magnitude,
  output logic signed [15:0] stick_angle,
  output logic signed [15:0] left_trigger,
  output logic signed [15:0] right_trigger,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [14:0]        cfg_data
);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_LOAD = 15'h0002,
    S_SQX  = 15'h0004,
    S_SQY  = 15'h0008,
    S_DZ   = 15'h0010,
    S_SQRT = 15'h0020,
    S_MAG  = 15'h0040,
    S_MAGW = 15'h0080,
    S_XDIV = 15'h0100,
    S_XW   = 15'h0200,
    S_YDIV = 15'h0400,
    S_YW   = 15'h0800,
    S_ROT  = 15'h1000,
    S_CORD = 15'h2000,
    S_FIN  = 15'h4000
  } state_t;

  state_t state;

  logic [15:0] raw_axes [8];
  logic [14:0] dz_left, dz_right;

  logic [1:0]         kind;
  logic signed [15:0] px, py;
  logic [15:0]        ax, ay;
  logic [14:0]        dz;
  logic [31:0]        r2;
  logic [47:0]        sq_src;
  logic [27:0]        sq_rem;
  logic [23:0]        rq;
  logic [4:0]         sq_cnt;
  logic [15:0]        mag;
  logic signed [15:0] res_x, res_y, res_ang;
  logic signed [27:0] cx, cy;
  logic signed [23:0] cz;
  logic [3:0]         cit;

  logic               map_ok;
  logic [2:0]         slot;
  logic [1:0]         kind_in;
  logic               accept;
  logic               out_load;

  // Code decode
  always_comb begin
    map_ok = 1'b1;
    slot = SLOT_LX;
    kind_in = KIND_OTHER;
    case (axis_code) inside
      6'd0: begin slot = SLOT_LX; kind_in = KIND_LEFT; end
      6'd1: begin slot = SLOT_LY; kind_in = KIND_LEFT; end
      6'd2: begin slot = SLOT_LT; kind_in = KIND_TRIG; end
      6'd3: begin slot = SLOT_RX; kind_in = KIND_RIGHT; end
      6'd4: begin slot = SLOT_RY; kind_in = KIND_RIGHT; end
      6'd5: begin slot = SLOT_RT; kind_in = KIND_TRIG; end
      6'd16: begin slot = SLOT_DPX; kind_in = KIND_OTHER; end
      6'd17: begin slot = SLOT_DPY; kind_in = KIND_OTHER; end
      default: map_ok = 1'b0;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  // Shared multiplier
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  always_comb begin
    case (state)
      S_SQX:   begin mul_a = ax; mul_b = ax; end
      S_SQY:   begin mul_a = ay; mul_b = ay; end
      S_DZ:    begin mul_a = {1'b0, dz}; mul_b = {1'b0, dz}; end
      S_XDIV:  begin mul_a = ax; mul_b = mag; end
      S_YDIV:  begin mul_a = ay; mul_b = mag; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Shared divider
  rdz_div_req_t     div_req;
  logic [DIV_W-1:0] div_q;
  logic             div_done;
  logic [14:0]      den;
  logic [23:0]      rq_off;

  assign den = FULL_SCALE - dz;
  assign rq_off = rq - {1'b0, dz, 8'b0};

  always_comb begin
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = rq;
    case (state)
      S_MAG: begin
        div_req.start = 1'b1;
        div_req.dividend = {1'b0, rq_off, 15'b0};
        div_req.divisor = {1'b0, den, 8'b0};
      end
      S_XDIV, S_YDIV: begin
        div_req.start = 1'b1;
        div_req.dividend = {mul_p, 8'b0};
      end
      default: ;
    endcase
  end

  rdz_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .quotient (div_q),
    .done     (div_done)
  );

  // Signed scale from quotient
  logic [15:0] q_sat_neg, q_sat_pos;
  assign q_sat_neg = (div_q > 40'd32768) ? 16'h8000 : div_q[15:0];
  assign q_sat_pos = (div_q > 40'd32767) ? 16'h7FFF : div_q[15:0];

  // Square root step
  logic [27:0] sq_sh, sq_trial, sq_diff;
  logic        sq_ge;
  assign sq_sh = {sq_rem[25:0], sq_src[47:46]};
  assign sq_trial = {2'b00, rq, 2'b01};
  assign sq_diff = sq_sh - sq_trial;
  assign sq_ge = (sq_sh >= sq_trial);

  // CORDIC step
  logic signed [27:0] xs, ys;
  logic signed [23:0] at;
  logic signed [23:0] cz_step;
  assign xs = cx >>> cit;
  assign ys = cy >>> cit;
  assign at = $signed({4'b0, atan_step(cit)});
  assign cz_step = !cy[27] ? cz + at : cz - at;

  // Angle rounding, taken from the angle after the current step
  logic signed [23:0] zr;
  always_comb begin
    zr = (cz_step + 24'sd64) >>> 7;
  end

  logic signed [27:0] xe, ye;
  assign xe = {{4{px[15]}}, px, 8'b0};
  assign ye = {{4{py[15]}}, py, 8'b0};

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      dz_left <= DZ_RESET;
      dz_right <= DZ_RESET;
      for (int i = 0; i < 8; i++) raw_axes[i] <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      if (cfg_wr_en) begin
        if (cfg_index == REG_DZ_LEFT) dz_left <= cfg_data;
        else dz_right <= cfg_data;
      end

      case (state)
        S_IDLE: begin
          if (accept && map_ok) begin
            raw_axes[slot] <= axis_value;
            kind <= kind_in;
            res_x <= '0;
            res_y <= '0;
            res_ang <= '0;
            mag <= '0;
            state <= (kind_in == KIND_LEFT || kind_in == KIND_RIGHT) ? S_LOAD : S_FIN;
          end
        end
        S_LOAD: begin
          if (kind == KIND_LEFT) begin
            px <= raw_axes[SLOT_LX];
            py <= raw_axes[SLOT_LY];
            ax <= raw_axes[SLOT_LX][15] ? 16'(-raw_axes[SLOT_LX]) : raw_axes[SLOT_LX];
            ay <= raw_axes[SLOT_LY][15] ? 16'(-raw_axes[SLOT_LY]) : raw_axes[SLOT_LY];
            dz <= dz_left;
          end else begin
            px <= raw_axes[SLOT_RX];
            py <= raw_axes[SLOT_RY];
            ax <= raw_axes[SLOT_RX][15] ? 16'(-raw_axes[SLOT_RX]) : raw_axes[SLOT_RX];
            ay <= raw_axes[SLOT_RY][15] ? 16'(-raw_axes[SLOT_RY]) : raw_axes[SLOT_RY];
            dz <= dz_right;
          end
          state <= S_SQX;
        end
        S_SQX: begin
          r2 <= mul_p;
          state <= S_SQY;
        end
        S_SQY: begin
          r2 <= r2 + mul_p;
          state <= S_DZ;
        end
        S_DZ: begin
          // zero vector or inside the deadzone gives all-zero stick fields
          if (r2 == 32'd0 || r2 < mul_p) begin
            state <= S_FIN;
          end else begin
            sq_src <= {r2, 16'b0};
            sq_rem <= '0;
            rq <= '0;
            sq_cnt <= 5'd24;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_src <= {sq_src[45:0], 2'b00};
          sq_rem <= sq_ge ? sq_diff : sq_sh;
          rq <= {rq[22:0], sq_ge};
          sq_cnt <= sq_cnt - 5'd1;
          if (sq_cnt == 5'd1) begin
            if (den == 15'd0) begin
              mag <= 16'h8000;
              state <= S_XDIV;
            end else begin
              state <= S_MAG;
            end
          end
        end
        S_MAG: state <= S_MAGW;
        S_MAGW: begin
          if (div_done) begin
            mag <= (div_q > 40'd32768) ? 16'h8000 : div_q[15:0];
            state <= S_XDIV;
          end
        end
        S_XDIV: state <= S_XW;
        S_XW: begin
          if (div_done) begin
            res_x <= px[15] ? 16'(-q_sat_neg) : q_sat_pos;
            state <= S_YDIV;
          end
        end
        S_YDIV: state <= S_YW;
        S_YW: begin
          if (div_done) begin
            res_y <= py[15] ? 16'(-q_sat_neg) : q_sat_pos;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          // quarter turn for the left half-plane
          if (px[15]) begin
            if (!py[15]) begin
              cx <= ye;
              cy <= -xe;
              cz <= HALF_PI_U20;
            end else begin
              cx <= -ye;
              cy <= xe;
              cz <= -HALF_PI_U20;
            end
          end else begin
            cx <= xe;
            cy <= ye;
            cz <= '0;
          end
          cit <= '0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (!cy[27]) begin
            cx <= cx + ys;
            cy <= cy - xs;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
          end
          cz <= cz_step;
          cit <= cit + 4'd1;
          // angle latched once the last step is done
          if (cit == 4'd15) begin
            if (zr > $signed({7'b0, ANGLE_MAX})) res_ang <= 16'(ANGLE_MAX);
            else if (zr < -$signed({7'b0, ANGLE_MAX})) res_ang <= -16'(ANGLE_MAX);
            else res_ang <= zr[15:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      update_kind <= kind;
      stick_x <= res_x;
      stick_y <= res_y;
      stick_magnitude <= mag;
      stick_angle <= res_ang;
      left_trigger <= raw_axes[SLOT_LT];
      right_trigger <= raw_axes[SLOT_RT];
    end
  end

  a_kind_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && update_kind[1] |-> stick_x == 16'sd0 && stick_y == 16'sd0
      && stick_magnitude == 16'd0 && stick_angle == 16'sd0)
    else $error("stick fields set on non-stick result");
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stick_magnitude <= 16'd32768)
    else $error("magnitude above full scale");
  a_mag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && stick_magnitude == 16'd0 |-> stick_x == 16'sd0 && stick_y == 16'sd0)
    else $error("nonzero axis with zero magnitude");

endmodule

// ----- hw/rtl/rdz_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
module rdz_div
  import rdz_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  rdz_div_req_t       req,
  output logic [DIV_W-1:0]   quotient,
  output logic               done
);

  logic [DSR_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DSR_W-1:0] dsr;
  logic [5:0]       cnt;
  logic             busy;
  logic [DSR_W:0]   shifted;
  logic [DSR_W+1:0] diff;
  logic             ge;

  // Trial subtract
  assign shifted = {rem, quo[DIV_W-1]};
  assign diff = {1'b0, shifted} - {2'b00, dsr};
  assign ge = !diff[DSR_W+1];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= '0;
        quo <= req.dividend;
        dsr <= req.divisor;
        cnt <= 6'(DIV_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    busy && cnt == 6'd1 && !req.start |=> done)
    else $error("divider missed done");

endmodule

// ----- dv/radial_deadzone_stick_conditioner_unit_checker.sv -----
// Checker: predicts stick, trigger and DPad results and compares them with the block.
module radial_deadzone_stick_conditioner_unit_checker
  import rdz_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [5:0]         axis_code,
  input  logic signed [15:0] axis_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         update_kind,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  input  logic [15:0]        stick_magnitude,
  input  logic signed [15:0] stick_angle,
  input  logic signed [15:0] left_trigger,
  input  logic signed [15:0] right_trigger,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [14:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] mag;
    logic [15:0] ang;
    logic [15:0] lt;
    logic [15:0] rt;
  } pad_update_t;

  pad_update_t expected_updates[$];
  logic signed [15:0] axis_store[8];
  logic [14:0] dz_left, dz_right;

  assign pending = expected_updates.size();

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, t, xs, ys;
    z = 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_U20;
      end else begin
        x = -y; y = t; z = -longint'(HALF_PI_U20);
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(4'(i));
      end else begin
        x -= ys; y += xs; z -= atan_step(4'(i));
      end
    end
    z = shr_floor(z + 64, 7);
    if (z > longint'(ANGLE_MAX)) z = ANGLE_MAX;
    if (z < -longint'(ANGLE_MAX)) z = -longint'(ANGLE_MAX);
    return z;
  endfunction

  function automatic longint scaled_axis(longint v, longint m, longint rq);
    longint q;
    q = ((v < 0) ? -v : v) * m * 256 / rq;
    if (v < 0) return (q > 32768) ? -32768 : -q;
    return (q > 32767) ? 32767 : q;
  endfunction

  // Stick conditioning for one stick: deadzone, rescale, direction
  function automatic void condition_stick(longint x, longint y, longint dz,
                                          ref pad_update_t u);
    longint r2, rq, den, m;
    r2 = x * x + y * y;
    if (r2 == 0 || r2 < dz * dz) return;
    rq = root_floor(r2 << 16);
    den = FULL_SCALE - dz;
    if (den <= 0) m = 32768;
    else begin
      m = (rq - dz * 256) * 32768 / (den * 256);
      if (m > 32768) m = 32768;
    end
    u.sx = 16'(scaled_axis(x, m, rq));
    u.sy = 16'(scaled_axis(y, m, rq));
    u.mag = 16'(m);
    u.ang = 16'(vector_angle(x, y));
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    pad_update_t u, w;
    int slot;
    if (rst) begin
      foreach (axis_store[i]) axis_store[i] = '0;
      dz_left = DZ_RESET;
      dz_right = DZ_RESET;
      expected_updates.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_DZ_LEFT) dz_left = cfg_data;
        else dz_right = cfg_data;
      end
      // Accepted request: update store and predict
      if (in_valid && in_ready) begin
        slot = (axis_code <= 5) ? int'(axis_code) : (axis_code == 16) ? 6 :
               (axis_code == 17) ? 7 : -1;
        if (slot >= 0) begin
          axis_store[slot] = axis_value;
          u = '0;
          case (axis_code)
            6'd0, 6'd1: u.kind = KIND_LEFT;
            6'd3, 6'd4: u.kind = KIND_RIGHT;
            6'd2, 6'd5: u.kind = KIND_TRIG;
            default:    u.kind = KIND_OTHER;
          endcase
          if (u.kind == KIND_LEFT)
            condition_stick(axis_store[SLOT_LX], axis_store[SLOT_LY], dz_left, u);
          else if (u.kind == KIND_RIGHT)
            condition_stick(axis_store[SLOT_RX], axis_store[SLOT_RY], dz_right, u);
          u.lt = axis_store[SLOT_LT];
          u.rt = axis_store[SLOT_RT];
          expected_updates.push_back(u);
        end
      end
      // Accepted result: compare with oldest prediction
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          report_mismatch("unexpected result kind", 16'(update_kind), 16'd0);
        end else begin
          w = expected_updates.pop_front();
          if (update_kind != w.kind) report_mismatch("update_kind", update_kind, w.kind);
          if (stick_x != w.sx) report_mismatch("stick_x", stick_x, w.sx);
          if (stick_y != w.sy) report_mismatch("stick_y", stick_y, w.sy);
          if (stick_magnitude != w.mag)
            report_mismatch("stick_magnitude", stick_magnitude, w.mag);
          if (stick_angle != w.ang) report_mismatch("stick_angle", stick_angle, w.ang);
          if (left_trigger != w.lt) report_mismatch("left_trigger", left_trigger, w.lt);
          if (right_trigger != w.rt) report_mismatch("right_trigger", right_trigger, w.rt);
        end
      end
    end
  end

endmodule

// ----- dv/radial_deadzone_stick_conditioner_unit_test.sv -----
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the conditioner.
module radial_deadzone_stick_conditioner_unit_test
  import rdz_pkg::*;
();

  localparam int IDLE_LIMIT = 20000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [5:0] axis_code;
  logic signed [15:0] axis_value;
  logic [1:0] update_kind;
  logic signed [15:0] stick_x, stick_y, stick_angle, left_trigger, right_trigger;
  logic [15:0] stick_magnitude;
  logic cfg_wr_en, cfg_index;
  logic [14:0] cfg_data;
  int errors, pending, idle_cycles;
  bit long_hold;

  radial_deadzone_stick_conditioner_unit dut (.*);
  radial_deadzone_stick_conditioner_unit_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
  endfunction

  // Offer one request, hold it until accepted, then an optional idle gap
  task automatic send_request(logic [5:0] code, logic [15:0] val);
    int g;
    in_valid <= 1;
    axis_code <= code;
    axis_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_deadzone(logic idx, logic [14:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [15:0] stick_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [5:0] random_code();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 6'($urandom_range(0, 1) * 3 + $urandom_range(0, 1));
    if (p < 82) return ($urandom_range(0, 1) != 0) ? 6'd2 : 6'd5;
    if (p < 90) return 6'd16 + 6'($urandom_range(0, 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // Receiver: random stalls plus one long hold-off
  initial begin
    out_ready = 0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        long_hold = 0;
      end
      out_ready <= ($urandom_range(0, 2) != 0);
      @(posedge clk);
      if (!out_ready && $urandom_range(0, 30) == 0)
        repeat (gap_len()) @(posedge clk);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("radial_deadzone_stick_conditioner_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    logic [14:0] dz_l[5], dz_r[5];
    dz_l = '{15'd8000, 15'd0, 15'd32766, 15'd1, 15'd2000};
    dz_r = '{15'd8000, 15'd32766, 15'd0, 15'd30000, 15'd500};
    rst = 1; in_valid = 0; axis_code = 0; axis_value = 0;
    cfg_wr_en = 0; cfg_index = 0; cfg_data = 0; long_hold = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: zero vector, extremes, triggers, DPad, unmapped codes
    send_request(6'd0, 16'd0);
    send_request(6'd0, 16'h7FFF);
    send_request(6'd1, 16'h8000);
    send_request(6'd0, 16'h8000);
    send_request(6'd1, 16'h7FFF);
    send_request(6'd0, 16'd100);
    send_request(6'd3, 16'hFFFF);
    send_request(6'd4, 16'h8000);
    send_request(6'd3, 16'h8000);
    send_request(6'd2, 16'h8000);
    send_request(6'd5, 16'h7FFF);
    send_request(6'd16, 16'hFFFF);
    send_request(6'd17, 16'h5555);
    send_request(6'd6, 16'h1234);
    send_request(6'd63, 16'hAAAA);
    drain();
    write_deadzone(REG_DZ_LEFT, 15'd0);
    write_deadzone(REG_DZ_RIGHT, 15'd32766);
    send_request(6'd0, 16'd0);
    send_request(6'd1, 16'd0);
    send_request(6'd1, 16'd1);
    send_request(6'd4, 16'h7FFF);
    send_request(6'd3, 16'h0);
    send_request(6'd0, 16'hFFFF);
    drain();
    // Random phases across deadzone settings
    for (int ph = 0; ph < 5; ph++) begin
      write_deadzone(REG_DZ_LEFT, (ph == 4) ? 15'($urandom) : dz_l[ph]);
      write_deadzone(REG_DZ_RIGHT, dz_r[ph]);
      for (int n = 0; n < 400; n++) begin
        if (ph == 2 && n == 50) long_hold = 1;
        send_request(random_code(), stick_value());
      end
      drain();
    end
    if (errors == 0)
      $display("radial_deadzone_stick_conditioner_unit_test: PASS");
    else
      $display("radial_deadzone_stick_conditioner_unit_test: FAIL");
    $finish;
  end

endmodule

// ----- radial_deadzone_stick_conditioner_unit.f -----
hw/rtl/rdz_pkg.sv
hw/rtl/rdz_div.sv
hw/rtl/radial_deadzone_stick_conditioner_unit.sv
dv/radial_deadzone_stick_conditioner_unit_checker.sv
dv/radial_deadzone_stick_conditioner_unit_test.sv
